[sv/sphck_pkg.sv]
// ----------------------------------------------------------------------------
// SPH cubic spline kernel package
// Word types of the two channels and the fixed constants of the kernel.
// ----------------------------------------------------------------------------
package sphck_pkg;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] nbr_x;
		logic signed [31:0] nbr_y;
		logic signed [31:0] nbr_z;
		logic               reversed;
	} in_word_t;

	typedef struct packed {
		logic        [31:0] kernel_value;
		logic signed [31:0] grad_x;
		logic signed [31:0] grad_y;
		logic signed [31:0] grad_z;
	} out_word_t;

	// round(2^32 / (4*pi))
	localparam logic [28:0] INV_4PI_Q32 = 29'd341782638;

	// one root bit per isqrt stage, one quotient bit per divider stage
	localparam int RT_STEPS = 32;
	localparam int DV_STEPS = 31;

endpackage

[sv/sphck_recip.sv]
// ----------------------------------------------------------------------------
// SPH kernel reciprocal unit
// Restoring divider that forms 1/h = 2^(FRAC_BITS+33) / support, one quotient
// bit per cycle, after each write of the support register.
// ----------------------------------------------------------------------------
module sphck_recip #(
	parameter int FRAC_BITS = 16,
	localparam int IHW = FRAC_BITS + 34,
	localparam int CW = $clog2(IHW + 1)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  logic [31:0]    dvs,
	output logic [IHW-1:0] ih
);

	logic [CW-1:0]  cnt_q;
	logic [31:0]    dvs_q;
	logic [31:0]    rem_q;
	logic [IHW-1:0] quo_q;
	logic [IHW-1:0] ih_q;
	logic [32:0]    trial;
	logic           take;
	logic [31:0]    rem_n;

	always_comb begin
		// the dividend is a single one at its top bit
		trial = {rem_q, (cnt_q == CW'(IHW))};
		take  = trial >= {1'b0, dvs_q};
		rem_n = take ? 32'(trial - {1'b0, dvs_q}) : trial[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ih_q  <= {{(IHW-34){1'b0}}, 1'b1, 33'd0};
		end else if (load) begin
			cnt_q <= CW'(IHW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				ih_q <= {quo_q[IHW-2:0], take};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			dvs_q <= dvs;
			rem_q <= '0;
			quo_q <= '0;
		end else if (cnt_q != '0) begin
			rem_q <= rem_n;
			quo_q <= {quo_q[IHW-2:0], take};
		end
	end

	assign ih = ih_q;

endmodule

[sv/sphck_ihmul.sv]
// ----------------------------------------------------------------------------
// SPH kernel scale multiplier
// Two-stage product floor(v * ih / 2^32) from four partial products, clamped
// to 2^(62-FRAC_BITS); above that bound the output saturates anyway.
// ----------------------------------------------------------------------------
module sphck_ihmul #(
	parameter int FRAC_BITS = 16,
	localparam int VW = 63 - FRAC_BITS,
	localparam int IHW = FRAC_BITS + 34,
	localparam int VH = VW - 32,
	localparam int IH_H = IHW - 32,
	localparam int PW = VW + IHW
) (
	input  logic           clk,
	input  logic           en,
	input  logic [VW-1:0]  v,
	input  logic [IHW-1:0] ih,
	output logic [VW-1:0]  p
);

	localparam logic [VW-1:0] CAP = {1'b1, {(VW-1){1'b0}}};

	logic [63:0]        p_ll_s1;
	logic [32+IH_H-1:0] p_lh_s1;
	logic [VH+32-1:0]   p_hl_s1;
	logic [VH+IH_H-1:0] p_hh_s1;
	logic [PW-1:0]      full_c;
	logic [PW-1:0]      shr_c;
	logic [VW-1:0]      p_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			p_ll_s1 <= 64'(v[31:0]) * 64'(ih[31:0]);
			p_lh_s1 <= (32+IH_H)'(v[31:0]) * (32+IH_H)'(ih[IHW-1:32]);
			p_hl_s1 <= (VH+32)'(v[VW-1:32]) * (VH+32)'(ih[31:0]);
			p_hh_s1 <= (VH+IH_H)'(v[VW-1:32]) * (VH+IH_H)'(ih[IHW-1:32]);
		end
	end

	always_comb begin
		full_c = PW'(p_ll_s1) + (PW'(p_lh_s1) << 32) + (PW'(p_hl_s1) << 32)
			+ (PW'(p_hh_s1) << 64);
		shr_c  = full_c >> 32;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s2 <= (shr_c >= PW'(CAP)) ? CAP : shr_c[VW-1:0];
		end
	end

	assign p = p_s2;

endmodule

[sv/sph_cubic_spline_kernel_3d_top.sv]
// ----------------------------------------------------------------------------
// SPH cubic spline kernel, 3D
// Kernel value and gradient of one particle/neighbour pair per word.
//
//   channel  direction  handshake                    word
//   config   in         cfg_wr_en                    cfg_wr_data (support)
//   in       in         in_valid / in_stall          in_word_t
//   out      out        out_valid / out_stall        out_word_t
//
// One word per cycle while the output is not stalled (3 setup stages,
// 32 isqrt, 31 divider, 5 polynomial and 8 scale stages, output register).
// A stalled output freezes the whole pipeline and raises in_stall.
// Reset sets support to 1.0. After a support write, 1/h is rebuilt before
// any word sent after the write reaches the scale stages.
// ----------------------------------------------------------------------------
module sph_cubic_spline_kernel_3d_top
	import sphck_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_word_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_word_t   out_data
);

	localparam int VW = 63 - FRAC_BITS;
	localparam int IHW = FRAC_BITS + 34;
	localparam int SH = 30 - FRAC_BITS;
	localparam int RT1 = 3 + RT_STEPS;
	localparam int DV1 = RT1 + DV_STEPS;
	localparam int NST = DV1 + 14;

	typedef struct packed {
		logic       far;
		logic       rzero;
		logic       rev;
		logic [2:0] neg;
	} flag_t;

	logic [NST:1]   vld_s;
	logic           adv;
	logic [31:0]    ks_q;
	logic [IHW-1:0] ih;

	// stage 1
	logic [2:0][31:0] pos_w;
	logic [2:0][31:0] nbr_w;
	logic [2:0][32:0] dif_c;
	logic [2:0][32:0] mag_c;
	logic [2:0]       neg_c;
	logic             far_c;
	logic [2:0][31:0] ad_s1;
	logic [2:0]       neg_s1;
	logic             rev_s1;
	logic             far_s1;

	// stage 2 / 3
	logic [2:0][63:0] sq_s2;
	logic [63:0]      ss_s2;
	logic [2:0][31:0] ad_s2;
	logic [2:0]       neg_s2;
	logic             rev_s2;
	logic             far_s2;
	logic [65:0]      sum_c;

	// shift lines
	flag_t            flg_s [3:NST-1];
	logic [2:0][31:0] ad_s  [3:RT1];

	// isqrt
	logic [33:0] rt_rem_s  [3:RT1];
	logic [31:0] rt_root_s [3:RT1];
	logic [63:0] rt_src_s  [3:RT1];

	// dividers
	logic [31:0]      dv_qrem_s [RT1+1:DV1];
	logic [30:0]      dv_qq_s   [RT1+1:DV1];
	logic [2:0][31:0] dv_urem_s [RT1+1:DV1];
	logic [2:0][30:0] dv_uq_s   [RT1+1:DV1];
	logic [31:0]      dv_r_s    [RT1+1:DV1];

	// polynomial stages
	logic [2:0][30:0] u_s [67:70];
	logic [31:0]      w_c;
	logic [30:0]      q30_s67;
	logic [31:0]      q2_s67;
	logic [30:0]      w_s67;
	logic [30:0]      w2_s67;
	logic             lo_s67;
	logic [30:0]      q3_s68;
	logic [30:0]      fw_s68;
	logic [32:0]      m30_s68;
	logic [31:0]      q2_s68;
	logic             lo_s68;
	logic [33:0]      f30_s69;
	logic [32:0]      m30_s69;
	logic [30:0]      c_s70;
	logic [29:0]      cm_s70;
	logic [3:0][VW-1:0] mv_s71;
	logic [3:0][VW-1:0] mulv [0:4];

	// output
	logic [32:0]      kk_c;
	logic [2:0][32:0] gg_c;
	logic [2:0][32:0] gm_c;
	logic [2:0][31:0] grad_c;
	out_word_t        res_c;
	out_word_t        out_s80;
	flag_t            fl_c;

	assign adv      = !(vld_s[NST] && out_stall);
	assign in_stall = vld_s[NST] && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NST-1:1], in_valid};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ks_q <= 32'd1 << FRAC_BITS;
		end else if (cfg_wr_en) begin
			ks_q <= cfg_wr_data;
		end
	end

	sphck_recip #(.FRAC_BITS(FRAC_BITS)) u_recip (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (cfg_wr_en),
		.dvs    (cfg_wr_data),
		.ih     (ih)
	);

	// ---- stage 1: difference, magnitude, per-axis support check
	assign pos_w = {in_data.pos_z, in_data.pos_y, in_data.pos_x};
	assign nbr_w = {in_data.nbr_z, in_data.nbr_y, in_data.nbr_x};

	always_comb begin
		far_c = 1'b0;
		for (int i = 0; i < 3; i++) begin
			dif_c[i] = {pos_w[i][31], pos_w[i]} - {nbr_w[i][31], nbr_w[i]};
			neg_c[i] = dif_c[i][32];
			mag_c[i] = neg_c[i] ? 33'(~dif_c[i] + 33'd1) : dif_c[i];
			if (mag_c[i] >= {1'b0, ks_q}) begin
				far_c = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				ad_s1[i] <= mag_c[i][31:0];
			end
			neg_s1 <= neg_c;
			rev_s1 <= in_data.reversed;
			far_s1 <= far_c;
		end
	end

	// ---- stage 2: squares
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				sq_s2[i] <= 64'(ad_s1[i]) * 64'(ad_s1[i]);
			end
			ss_s2  <= 64'(ks_q) * 64'(ks_q);
			ad_s2  <= ad_s1;
			neg_s2 <= neg_s1;
			rev_s2 <= rev_s1;
			far_s2 <= far_s1;
		end
	end

	// ---- stage 3: squared radius against support squared
	assign sum_c = 66'(sq_s2[0]) + 66'(sq_s2[1]) + 66'(sq_s2[2]);

	always_ff @(posedge clk) begin
		if (adv) begin
			flg_s[3]     <= '{far: far_s2 || (sum_c >= 66'(ss_s2)), rzero: (sum_c == '0),
				rev: rev_s2, neg: neg_s2};
			ad_s[3]      <= ad_s2;
			rt_rem_s[3]  <= '0;
			rt_root_s[3] <= '0;
			rt_src_s[3]  <= sum_c[63:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 4; k <= NST-1; k++) begin
				flg_s[k] <= flg_s[k-1];
			end
			for (int k = 4; k <= RT1; k++) begin
				ad_s[k] <= ad_s[k-1];
			end
		end
	end

	// ---- isqrt: one root bit per stage
	for (genvar k = 4; k <= RT1; k++) begin : g_rt
		logic [35:0] rsh;
		logic [35:0] trial;
		logic        take;

		always_comb begin
			rsh   = {rt_rem_s[k-1], rt_src_s[k-1][63:62]};
			trial = {2'b00, rt_root_s[k-1], 2'b01};
			take  = rsh >= trial;
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rt_rem_s[k]  <= take ? 34'(rsh - trial) : rsh[33:0];
				rt_root_s[k] <= {rt_root_s[k-1][30:0], take};
				rt_src_s[k]  <= {rt_src_s[k-1][61:0], 2'b00};
			end
		end
	end

	// ---- dividers: q = r*2^31/S and u = ad*2^30/r, one bit per stage
	for (genvar k = RT1 + 1; k <= DV1; k++) begin : g_dv
		logic [31:0]      qr_in;
		logic [30:0]      qq_in;
		logic [2:0][31:0] ur_in;
		logic [2:0][30:0] uq_in;
		logic [31:0]      r_in;
		logic [32:0]      qt;
		logic             qbit;
		logic [2:0][32:0] ut;
		logic [2:0]       ubit;

		if (k == RT1 + 1) begin : g_first
			assign qr_in = rt_root_s[RT1];
			assign qq_in = '0;
			assign ur_in = ad_s[RT1];
			assign uq_in = '0;
			assign r_in  = rt_root_s[RT1];
		end else begin : g_next
			assign qr_in = dv_qrem_s[k-1];
			assign qq_in = dv_qq_s[k-1];
			assign ur_in = dv_urem_s[k-1];
			assign uq_in = dv_uq_s[k-1];
			assign r_in  = dv_r_s[k-1];
		end

		always_comb begin
			qt   = {qr_in, 1'b0};
			qbit = qt >= {1'b0, ks_q};
			for (int i = 0; i < 3; i++) begin
				// ad may equal r: take the top quotient bit before shifting
				ut[i]   = (k == RT1 + 1) ? {1'b0, ur_in[i]} : {ur_in[i], 1'b0};
				ubit[i] = ut[i] >= {1'b0, r_in};
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_qrem_s[k] <= qbit ? 32'(qt - {1'b0, ks_q}) : qt[31:0];
				dv_qq_s[k]   <= {qq_in[29:0], qbit};
				for (int i = 0; i < 3; i++) begin
					dv_urem_s[k][i] <= ubit[i] ? 32'(ut[i] - {1'b0, r_in}) : ut[i][31:0];
					dv_uq_s[k][i]   <= {uq_in[i][29:0], ubit[i]};
				end
				dv_r_s[k] <= r_in;
			end
		end
	end

	// ---- polynomial stages
	assign w_c = 32'h8000_0000 - 32'(dv_qq_s[DV1]);

	always_ff @(posedge clk) begin
		if (adv) begin
			q30_s67 <= dv_qq_s[DV1];
			q2_s67  <= 32'((62'(dv_qq_s[DV1]) * 62'(dv_qq_s[DV1])) >> 30);
			w_s67   <= w_c[30:0];
			w2_s67  <= 31'((62'(w_c[30:0]) * 62'(w_c[30:0])) >> 30);
			lo_s67  <= !dv_qq_s[DV1][30];
			u_s[67] <= dv_uq_s[DV1];
			for (int k = 68; k <= 70; k++) begin
				u_s[k] <= u_s[k-1];
			end

			q3_s68  <= 31'((63'(q2_s67) * 63'(q30_s67)) >> 30);
			fw_s68  <= 31'((62'(w2_s67) * 62'(w_s67)) >> 30);
			m30_s68 <= lo_s67 ? 33'(36'(q30_s67) * 36'd12 - 36'(q2_s67) * 36'd9)
				: 33'(33'(w2_s67) * 33'd3);
			q2_s68  <= q2_s67;
			lo_s68  <= lo_s67;

			f30_s69 <= lo_s68 ? 34'(35'h1_0000_0000 + 35'(q3_s68) * 35'd3
				- 35'(q2_s68) * 35'd6) : 34'(fw_s68);
			m30_s69 <= m30_s68;

			c_s70  <= 31'((63'(f30_s69) * 63'(INV_4PI_Q32)) >> 32);
			cm_s70 <= 30'((62'(m30_s69) * 62'(INV_4PI_Q32)) >> 32);

			mv_s71[0] <= VW'(c_s70);
			for (int i = 0; i < 3; i++) begin
				mv_s71[i+1] <= VW'((61'(cm_s70) * 61'(u_s[70][i])) >> 30);
			end
		end
	end

	// ---- scale by 1/h: kernel three times, gradient four times
	assign mulv[0] = mv_s71;

	for (genvar j = 1; j <= 4; j++) begin : g_step
		for (genvar l = 0; l < 4; l++) begin : g_lane
			if (j == 4 && l == 0) begin : g_kdly
				logic [VW-1:0] kd_s78;
				logic [VW-1:0] kd_s79;

				always_ff @(posedge clk) begin
					if (adv) begin
						kd_s78 <= mulv[3][0];
						kd_s79 <= kd_s78;
					end
				end

				assign mulv[4][0] = kd_s79;
			end else begin : g_mul
				sphck_ihmul #(.FRAC_BITS(FRAC_BITS)) u_mul (
					.clk (clk),
					.en  (adv),
					.v   (mulv[j-1][l]),
					.ih  (ih),
					.p   (mulv[j][l])
				);
			end
		end
	end

	// ---- output: shift down, saturate, apply sign
	always_comb begin
		fl_c = flg_s[NST-1];
		kk_c = 33'(mulv[4][0] >> SH);
		res_c.kernel_value = fl_c.far ? 32'd0 : (kk_c[32] ? 32'hFFFF_FFFF : kk_c[31:0]);
		for (int i = 0; i < 3; i++) begin
			gg_c[i] = 33'(mulv[4][i+1] >> SH);
			gm_c[i] = '0;
			if (fl_c.far || fl_c.rzero || gg_c[i] == '0) begin
				grad_c[i] = '0;
			end else if (fl_c.neg[i] != fl_c.rev) begin
				gm_c[i]   = (gg_c[i] > 33'h0_8000_0000) ? 33'h0_8000_0000 : gg_c[i];
				grad_c[i] = 32'd0 - gm_c[i][31:0];
			end else begin
				grad_c[i] = (gg_c[i] > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : gg_c[i][31:0];
			end
		end
		res_c.grad_x = grad_c[0];
		res_c.grad_y = grad_c[1];
		res_c.grad_z = grad_c[2];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_s80 <= res_c;
		end
	end

	assign out_valid = vld_s[NST];
	assign out_data  = out_s80;

endmodule

[sim/tb_sph_cubic_spline_kernel_3d_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cubic spline kernel testbench
// Drives random and corner position pairs through the kernel under several
// support settings and idle/stall mixes, and checks every output word
// against a bit-accurate fixed-point predictor held in a scoreboard.
// ----------------------------------------------------------------------------
module tb_sph_cubic_spline_kernel_3d_top;
	import sphck_pkg::*;

	localparam int FB = 16;
	localparam int LATENCY = 80;
	localparam logic [63:0] ONE30 = 64'd1 << 30;
	localparam logic [63:0] UMAX = '1;

	class kernel_scoreboard;
		out_word_t pending[$];
		logic [31:0] support;
		int errors;

		function new();
			support = 32'd1 << FB;
			errors = 0;
		endfunction

		// floor(a*b/2^sh), saturating at 2^64-1
		function logic [63:0] mulsh(logic [63:0] a, logic [63:0] b, int sh);
			logic [127:0] p;
			p = a * b;
			p = p >> sh;
			if (p[127:64] != 0)
				return UMAX;
			return p[63:0];
		endfunction

		function logic [63:0] isqrt(logic [63:0] v);
			logic [63:0] res, bit_v;
			res = 0;
			bit_v = 64'd1 << 62;
			while (bit_v > v)
				bit_v = bit_v >> 2;
			while (bit_v != 0) begin
				if (v >= res + bit_v) begin
					v = v - (res + bit_v);
					res = (res >> 1) + bit_v;
				end else begin
					res = res >> 1;
				end
				bit_v = bit_v >> 2;
			end
			return res;
		endfunction

		function out_word_t evaluate(in_word_t w);
			out_word_t o;
			logic [63:0] s_sup, ad[3], s, r, q30, q2, q3, f30, m30, ih, c, cm, v, u, wq, w2;
			logic [64:0] acc;
			logic signed [63:0] d;
			logic neg[3];
			logic [31:0] pv[3], nv[3];
			o = '0;
			s_sup = {32'd0, support};
			pv[0] = w.pos_x; pv[1] = w.pos_y; pv[2] = w.pos_z;
			nv[0] = w.nbr_x; nv[1] = w.nbr_y; nv[2] = w.nbr_z;
			for (int i = 0; i < 3; i++) begin
				d = 64'(signed'(pv[i])) - 64'(signed'(nv[i]));
				neg[i] = d < 0;
				ad[i] = neg[i] ? 64'(-d) : 64'(d);
				if (ad[i] >= s_sup)
					return o;
			end
			acc = 0;
			for (int i = 0; i < 3; i++)
				acc = acc + 65'(ad[i] * ad[i]);
			// support^2 fits 64 bits, so a carry is always outside
			if (acc[64] || acc[63:0] >= s_sup * s_sup)
				return o;
			s = acc[63:0];
			r = isqrt(s);
			q30 = (r << 31) / s_sup;
			q2 = (q30 * q30) >> 30;
			if (q30 < ONE30) begin
				q3 = (q2 * q30) >> 30;
				f30 = 4 * ONE30 + 3 * q3 - 6 * q2;
				m30 = 12 * q30 - 9 * q2;
			end else begin
				wq = 2 * ONE30 - q30;
				w2 = (wq * wq) >> 30;
				f30 = (w2 * wq) >> 30;
				m30 = 3 * w2;
			end
			ih = (64'd1 << (FB + 33)) / s_sup;
			c = mulsh(f30, 64'(INV_4PI_Q32), 32);
			cm = mulsh(m30, 64'(INV_4PI_Q32), 32);
			v = c;
			for (int k = 0; k < 3; k++)
				v = mulsh(v, ih, 32);
			v = v >> (30 - FB);
			o.kernel_value = (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
			if (s == 0)
				return o;
			for (int i = 0; i < 3; i++) begin
				logic [31:0] g;
				u = (ad[i] << 30) / r;
				v = mulsh(cm, u, 30);
				for (int k = 0; k < 4; k++)
					v = mulsh(v, ih, 32);
				v = v >> (30 - FB);
				if (v == 0) begin
					g = 0;
				end else if (neg[i] != w.reversed) begin
					if (v > 64'h8000_0000)
						v = 64'h8000_0000;
					g = 32'(0 - v);
				end else begin
					if (v > 64'h7FFF_FFFF)
						v = 64'h7FFF_FFFF;
					g = v[31:0];
				end
				if (i == 0) o.grad_x = g;
				else if (i == 1) o.grad_y = g;
				else o.grad_z = g;
			end
			return o;
		endfunction

		function void note_input(in_word_t w);
			pending.push_back(evaluate(w));
		endfunction

		function void check_result(out_word_t got);
			out_word_t exp_w;
			if (pending.size() == 0) begin
				$error("unexpected output word %h", got);
				errors++;
				return;
			end
			exp_w = pending.pop_front();
			if (got.kernel_value !== exp_w.kernel_value) begin
				$error("kernel_value exp %h got %h", exp_w.kernel_value, got.kernel_value);
				errors++;
			end
			if (got.grad_x !== exp_w.grad_x) begin
				$error("grad_x exp %h got %h", exp_w.grad_x, got.grad_x);
				errors++;
			end
			if (got.grad_y !== exp_w.grad_y) begin
				$error("grad_y exp %h got %h", exp_w.grad_y, got.grad_y);
				errors++;
			end
			if (got.grad_z !== exp_w.grad_z) begin
				$error("grad_z exp %h got %h", exp_w.grad_z, got.grad_z);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n, cfg_wr_en, in_valid, in_stall, out_valid, out_stall;
	logic [31:0] cfg_wr_data;
	in_word_t in_data;
	out_word_t out_data;

	int send_idle_pct, recv_stall_pct;
	kernel_scoreboard sb;

	sph_cubic_spline_kernel_3d_top #(.FRAC_BITS(FB)) uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	initial begin
		#20ms;
		$display("== FAIL ==");
		$finish;
	end

	// receiver: check accepted words, stall at random
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				sb.check_result(out_data);
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	task automatic write_support(logic [31:0] val);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.support = val;
	endtask

	// valid stays high after an accepted word until the next idle or word
	task automatic send_word(in_word_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_input(w);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_span(logic [31:0] sup);
		// distance component mostly inside the support
		case ($urandom_range(3))
			0: return $urandom;
			1: return (sup == 0) ? 32'd0 : $urandom_range(sup - 1);
			default: return (sup < 2) ? 32'd0 : $urandom_range(sup / 2);
		endcase
	endfunction

	function automatic in_word_t rand_pair(logic [31:0] sup);
		in_word_t w;
		logic [31:0] dd[3];
		w.pos_x = $urandom; w.pos_y = $urandom; w.pos_z = $urandom;
		w.reversed = $urandom_range(1);
		for (int i = 0; i < 3; i++) begin
			dd[i] = rand_span(sup);
			if ($urandom_range(1))
				dd[i] = -dd[i];
		end
		w.nbr_x = w.pos_x - dd[0];
		w.nbr_y = w.pos_y - dd[1];
		w.nbr_z = w.pos_z - dd[2];
		if ($urandom_range(9) == 0) begin
			w.nbr_x = $urandom; w.nbr_y = $urandom; w.nbr_z = $urandom;
		end
		return w;
	endfunction

	function automatic in_word_t mk(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
			logic [31:0] nx, logic [31:0] ny, logic [31:0] nz, logic rv);
		in_word_t w;
		w.pos_x = px; w.pos_y = py; w.pos_z = pz;
		w.nbr_x = nx; w.nbr_y = ny; w.nbr_z = nz;
		w.reversed = rv;
		return w;
	endfunction

	initial begin
		logic [31:0] supports[6];
		sb = new();
		supports = '{32'h0001_0000, 32'd1, 32'hFFFF_FFFF, 32'h0000_0100,
			32'h0040_0000, 32'h0000_8000};
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: coincident, axis, extremes, outside, reversed; reset, zero, max support
		send_word(mk(0, 0, 0, 0, 0, 0, 0));
		send_word(mk(32'h8000, 0, 0, 0, 0, 0, 0));
		send_word(mk(32'h8000, 0, 0, 0, 0, 0, 1));
		send_word(mk(0, 0, 0, 32'h4000, 32'h4000, 32'h4000, 0));
		send_word(mk(0, 0, 0, 32'h4000, 32'h4000, 32'h4000, 1));
		send_word(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1));
		send_word(mk(32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 0, 0, 0));
		send_word(mk(32'hFFFF, 0, 0, 0, 0, 0, 0));
		send_word(mk(32'h10000, 0, 0, 0, 0, 0, 0));
		send_word(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1));
		send_word(mk(1, 1, 1, 0, 0, 0, 0));
		send_word(mk(32'hFFFF_FFFF, 0, 0, 0, 0, 0, 1));
		send_word(mk(32'hB000, 32'hB000, 0, 0, 0, 0, 0));
		drain();
		write_support(32'd0);
		send_word(mk(0, 0, 0, 0, 0, 0, 0));
		send_word(mk(1, 0, 0, 0, 0, 0, 1));
		drain();
		write_support(32'hFFFF_FFFF);
		send_word(mk(0, 0, 0, 0, 0, 0, 0));
		send_word(mk(32'h7FFF_FFFF, 0, 0, 32'h8000_0001, 0, 0, 0));
		send_word(mk(32'h4000_0000, 32'h4000_0000, 0, 0, 0, 0, 1));
		send_word(mk(1, 0, 0, 0, 0, 0, 1));
		drain();

		// random phases over several supports and idle mixes
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
				default: begin send_idle_pct = 25; recv_stall_pct = 25; end
			endcase
			write_support(supports[ph % 6]);
			for (int n = 0; n < 62; n++) begin
				send_word(rand_pair(sb.support));
				// hold off until the pipe empties
				if (n == 30 && ph == 3) begin
					in_valid <= 1'b0;
					while (sb.pending.size() != 0)
						@(posedge clk);
				end
			end
			drain();
		end

		if (sb.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule

[sim.f]
sv/sphck_pkg.sv
sv/sphck_recip.sv
sv/sphck_ihmul.sv
sv/sph_cubic_spline_kernel_3d_top.sv
sim/tb_sph_cubic_spline_kernel_3d_top.sv
